@@ rtl/cau_pkg.sv @@
// shared opcodes, widths and arctangent table for the complex arithmetic unit
package cau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    // width of the angle accumulator, enough for pi plus the sum of all steps
    localparam int ANGLE_BITS    = 35;
    localparam int ATAN_ENTRIES  = 31;
    localparam logic [32:0] PI_Q30 = 33'd3373259426;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_CONJ = 4'd4,
        OP_NEG  = 4'd5,
        OP_ABS  = 4'd6,
        OP_MAG  = 4'd7,
        OP_ARG  = 4'd8,
        OP_CMP  = 4'd9
    } op_t;

    // atan(2^-idx) in Q2.30
    function automatic logic [32:0] atan_q30(input int idx);
        logic [32:0] v;
        unique case (idx)
            0:  v = 33'd843314857;
            1:  v = 33'd497837829;
            2:  v = 33'd263043837;
            3:  v = 33'd133525159;
            4:  v = 33'd67021687;
            5:  v = 33'd33543516;
            6:  v = 33'd16775851;
            7:  v = 33'd8388437;
            8:  v = 33'd4194283;
            9:  v = 33'd2097149;
            10: v = 33'd1048576;
            11: v = 33'd524288;
            12: v = 33'd262144;
            13: v = 33'd131072;
            14: v = 33'd65536;
            15: v = 33'd32768;
            16: v = 33'd16384;
            17: v = 33'd8192;
            18: v = 33'd4096;
            19: v = 33'd2048;
            20: v = 33'd1024;
            21: v = 33'd512;
            22: v = 33'd256;
            23: v = 33'd128;
            24: v = 33'd64;
            25: v = 33'd32;
            26: v = 33'd16;
            27: v = 33'd8;
            28: v = 33'd4;
            29: v = 33'd2;
            30: v = 33'd1;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

    // Q2.30 angle rounded to nearest at frac fraction bits
    function automatic logic [ANGLE_BITS-1:0] angle_frac(input logic [32:0] q30,
                                                         input int frac);
        logic [ANGLE_BITS-1:0] v;
        int sh;
        v  = ANGLE_BITS'(q30);
        sh = 30 - frac;
        if (sh > 0)
        begin
            v = (v + (ANGLE_BITS'(1) << (sh - 1))) >> sh;
        end
        return v;
    endfunction

endpackage

@@ rtl/complex_arithmetic_unit_top.sv @@
// pipelined complex arithmetic unit: add, sub, mul, div, conj, neg, abs, magnitude, argument, compare
//
// Takes one item in every clock cycle (busy is always low) and returns one result per item, in
// the order accepted, as a one-cycle pulse on done; the receiver cannot stall the unit. A result
// passes through the input, product and sum registers, then the bit-per-stage chain that follows
// the multiplier and adder stages, then the output register. In that chain divide and square root
// make one quotient or root bit in each of WORD_BITS stages, and the arctangent runs one CORDIC
// rotation per stage alongside them. Operands and results are signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default); parts beyond range saturate and raise overflow.
module complex_arithmetic_unit_top #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [3:0]                  opcode,
    input  logic signed [WORD_BITS-1:0] a_real,
    input  logic signed [WORD_BITS-1:0] a_imag,
    input  logic signed [WORD_BITS-1:0] b_real,
    input  logic signed [WORD_BITS-1:0] b_imag,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] res_real,
    output logic signed [WORD_BITS-1:0] res_imag,
    output logic                        mag_less,
    output logic                        mag_equal,
    output logic                        mag_greater,
    output logic                        div_by_zero,
    output logic                        overflow
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W + 1;
    localparam int CW  = W + 3;
    localparam int ZW  = cau_pkg::ANGLE_BITS;
    localparam int SW  = (2 * W + 2 > ZW) ? 2 * W + 2 : ZW;
    localparam int CS  = (F + 1 < cau_pkg::ATAN_ENTRIES) ? F + 1 : cau_pkg::ATAN_ENTRIES;
    localparam int NIT = (W > CS) ? W : CS;
    localparam int PRE = (W > 61) ? W - 61 : 0;
    localparam int LAT = NIT + 5;

    localparam logic signed [SW-1:0] MAXV     = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV     = -(SW'(1) << (W - 1));
    localparam logic signed [SW-1:0] FRAC_RND = (SW'(1) << F) - SW'(1);
    localparam logic signed [SW-1:0] OVER_MAG = SW'(1) << W;
    localparam logic signed [ZW-1:0] PI_ANG   = cau_pkg::angle_frac(cau_pkg::PI_Q30, F);

    typedef struct packed {
        logic [W-1:0] val;
        logic         ovf;
    } sat_t;

    typedef struct packed {
        cau_pkg::op_t op;
        logic [W-1:0] fin_re;
        logic [W-1:0] fin_im;
        logic         ovf;
        logic         less;
        logic         equal;
        logic         greater;
        logic         dz;
    } tag_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

    typedef struct packed {
        logic [PW-1:0] p;
        logic [W-1:0]  l;
        logic [W-1:0]  q;
    } lane_t;

    typedef struct packed {
        tag_t          tag;
        cord_t         cord;
        logic [PW-1:0] den;
        lane_t         ln_re;
        lane_t         ln_im;
        logic          neg_re;
        logic          neg_im;
        logic          big_re;
        logic          big_im;
    } it_t;

    // clamp to the signed word range
    function automatic sat_t sat_word(input logic signed [SW-1:0] v);
        sat_t r;
        if (v > MAXV)
        begin
            r.val = MAXV[W-1:0];
            r.ovf = 1'b1;
        end
        else if (v < MINV)
        begin
            r.val = MINV[W-1:0];
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // drop the fraction bits, rounding toward zero
    function automatic logic signed [SW-1:0] trunc_frac(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v;
        if (v < 0)
        begin
            t = v + FRAC_RND;
        end
        return t >>> F;
    endfunction

    // signed quotient part, oversized quotients pushed past the range
    function automatic sat_t div_part(input logic [W-1:0] q, input logic neg, input logic big);
        logic signed [SW-1:0] m;
        m = SW'({1'b0, q});
        if (big)
        begin
            m = OVER_MAG;
        end
        if (neg)
        begin
            m = -m;
        end
        return sat_word(m);
    endfunction

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input stage
    logic                s0_valid_reg;
    cau_pkg::op_t        s0_op_reg;
    logic signed [W-1:0] s0_ar_reg;
    logic signed [W-1:0] s0_ai_reg;
    logic signed [W-1:0] s0_br_reg;
    logic signed [W-1:0] s0_bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_op_reg <= cau_pkg::op_t'(opcode);
            s0_ar_reg <= a_real;
            s0_ai_reg <= a_imag;
            s0_br_reg <= b_real;
            s0_bi_reg <= b_imag;
        end
    end

    // element-wise operations, operand selection for the multipliers, cordic start point
    logic signed [W:0]     ar1;
    logic signed [W:0]     ai1;
    logic signed [W:0]     br1;
    logic signed [W:0]     bi1;
    logic signed [W:0]     sre;
    logic signed [W:0]     sim;
    sat_t                  sat0_re;
    sat_t                  sat0_im;
    logic                  use_sq;
    logic [W-1:0]          abs_ar;
    logic [W-1:0]          abs_ai;
    logic [W-1:0]          ymag;
    logic signed [2*W-1:0] prod_next [6];
    tag_t                  s1_tag_next;
    cord_t                 s1_cord_next;

    assign ar1 = (W + 1)'(s0_ar_reg);
    assign ai1 = (W + 1)'(s0_ai_reg);
    assign br1 = (W + 1)'(s0_br_reg);
    assign bi1 = (W + 1)'(s0_bi_reg);

    always_comb
    begin
        unique case (s0_op_reg)
            cau_pkg::OP_ADD:
            begin
                sre = ar1 + br1;
                sim = ai1 + bi1;
            end
            cau_pkg::OP_SUB:
            begin
                sre = ar1 - br1;
                sim = ai1 - bi1;
            end
            cau_pkg::OP_CONJ:
            begin
                sre = ar1;
                sim = -ai1;
            end
            cau_pkg::OP_NEG:
            begin
                sre = -ar1;
                sim = -ai1;
            end
            cau_pkg::OP_ABS:
            begin
                sre = (ar1 < 0) ? -ar1 : ar1;
                sim = (ai1 < 0) ? -ai1 : ai1;
            end
            default:
            begin
                sre = '0;
                sim = '0;
            end
        endcase
    end

    assign sat0_re = sat_word(SW'(sre));
    assign sat0_im = sat_word(SW'(sim));

    always_comb
    begin
        s1_tag_next         = '0;
        s1_tag_next.op      = s0_op_reg;
        s1_tag_next.fin_re  = sat0_re.val;
        s1_tag_next.fin_im  = sat0_im.val;
        s1_tag_next.ovf     = sat0_re.ovf | sat0_im.ovf;
    end

    assign use_sq = (s0_op_reg == cau_pkg::OP_MAG) || (s0_op_reg == cau_pkg::OP_CMP);

    assign prod_next[0] = s0_ar_reg * (use_sq ? s0_ar_reg : s0_br_reg);
    assign prod_next[1] = s0_ai_reg * (use_sq ? s0_ai_reg : s0_bi_reg);
    assign prod_next[2] = s0_ai_reg * s0_br_reg;
    assign prod_next[3] = s0_ar_reg * s0_bi_reg;
    assign prod_next[4] = s0_br_reg * s0_br_reg;
    assign prod_next[5] = s0_bi_reg * s0_bi_reg;

    assign abs_ar = s0_ar_reg[W-1] ? W'(-ar1) : W'(ar1);
    assign abs_ai = s0_ai_reg[W-1] ? W'(-ai1) : W'(ai1);
    assign ymag   = abs_ai >> PRE;

    // a left-half point is mirrored onto the right half with pi preloaded
    always_comb
    begin
        s1_cord_next.x = CW'(abs_ar >> PRE);
        if (s0_ai_reg[W-1] ^ s0_ar_reg[W-1])
        begin
            s1_cord_next.y = -$signed(CW'(ymag));
        end
        else
        begin
            s1_cord_next.y = CW'(ymag);
        end
        if (s0_ar_reg[W-1])
        begin
            s1_cord_next.z = s0_ai_reg[W-1] ? -PI_ANG : PI_ANG;
        end
        else
        begin
            s1_cord_next.z = '0;
        end
    end

    // product stage
    logic                  s1_valid_reg;
    tag_t                  s1_tag_reg;
    cord_t                 s1_cord_reg;
    logic signed [2*W-1:0] s1_prod_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= s1_tag_next;
        s1_cord_reg <= s1_cord_next;
        s1_prod_reg <= prod_next;
    end

    // sums of products: real and imaginary numerators, divisor or squared magnitudes
    logic signed [2*W:0] p0;
    logic signed [2*W:0] p1;
    logic signed [2*W:0] p2;
    logic signed [2*W:0] p3;
    logic signed [2*W:0] sa_next;
    logic signed [2*W:0] sb_next;
    logic signed [2*W:0] den_next;

    assign p0 = (2 * W + 1)'(s1_prod_reg[0]);
    assign p1 = (2 * W + 1)'(s1_prod_reg[1]);
    assign p2 = (2 * W + 1)'(s1_prod_reg[2]);
    assign p3 = (2 * W + 1)'(s1_prod_reg[3]);

    assign sa_next  = (s1_tag_reg.op == cau_pkg::OP_MUL) ? p0 - p1 : p0 + p1;
    assign sb_next  = (s1_tag_reg.op == cau_pkg::OP_MUL) ? p2 + p3 : p2 - p3;
    assign den_next = (2 * W + 1)'(s1_prod_reg[4]) + (2 * W + 1)'(s1_prod_reg[5]);

    // sum stage
    logic                s2_valid_reg;
    tag_t                s2_tag_reg;
    cord_t               s2_cord_reg;
    logic signed [2*W:0] s2_sa_reg;
    logic signed [2*W:0] s2_sb_reg;
    logic signed [2*W:0] s2_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_tag_reg  <= s1_tag_reg;
        s2_cord_reg <= s1_cord_reg;
        s2_sa_reg   <= sa_next;
        s2_sb_reg   <= sb_next;
        s2_den_reg  <= den_next;
    end

    // multiply scaling, compare flags, divider and square root set-up
    sat_t          mul_re;
    sat_t          mul_im;
    logic [PW-1:0] na;
    logic [PW-1:0] nb;
    logic [PW-1:0] den_u;
    logic [PW-1:0] pre_re;
    logic [PW-1:0] pre_im;
    it_t           it0_next;

    assign mul_re = sat_word(trunc_frac(SW'(s2_sa_reg)));
    assign mul_im = sat_word(trunc_frac(SW'(s2_sb_reg)));
    assign na     = (s2_sa_reg < 0) ? PW'(-s2_sa_reg) : PW'(s2_sa_reg);
    assign nb     = (s2_sb_reg < 0) ? PW'(-s2_sb_reg) : PW'(s2_sb_reg);
    assign den_u  = PW'(s2_den_reg);
    assign pre_re = na >> (W - F);
    assign pre_im = nb >> (W - F);

    always_comb
    begin
        it0_next      = '0;
        it0_next.tag  = s2_tag_reg;
        it0_next.cord = s2_cord_reg;
        it0_next.den  = den_u;
        unique case (s2_tag_reg.op)
            cau_pkg::OP_MUL:
            begin
                it0_next.tag.fin_re = mul_re.val;
                it0_next.tag.fin_im = mul_im.val;
                it0_next.tag.ovf    = mul_re.ovf | mul_im.ovf;
            end
            cau_pkg::OP_CMP:
            begin
                it0_next.tag.less    = s2_sa_reg < s2_den_reg;
                it0_next.tag.equal   = s2_sa_reg == s2_den_reg;
                it0_next.tag.greater = s2_sa_reg > s2_den_reg;
            end
            cau_pkg::OP_DIV:
            begin
                it0_next.tag.dz = (den_u == '0);
            end
            default:
            begin
                it0_next.tag.dz = 1'b0;
            end
        endcase
        it0_next.ln_re.p = (s2_tag_reg.op == cau_pkg::OP_MAG) ? PW'(s2_sa_reg) : pre_re;
        it0_next.ln_re.l = W'(na << F);
        it0_next.ln_im.p = pre_im;
        it0_next.ln_im.l = W'(nb << F);
        it0_next.neg_re  = s2_sa_reg < 0;
        it0_next.neg_im  = s2_sb_reg < 0;
        it0_next.big_re  = pre_re >= den_u;
        it0_next.big_im  = pre_im >= den_u;
    end

    // bit-per-stage chain: quotient or root bits and cordic rotations
    logic it_valid_reg [NIT+1];
    it_t  it_reg       [NIT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_valid_reg[0] <= 1'b0;
        end
        else
        begin
            it_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg[0] <= it0_next;
    end

    for (genvar k = 0; k < NIT; k++)
    begin : g_iter
        it_t                  it_next;
        logic [PW-1:0]        ps_im;
        logic [PW-1:0]        a0;
        logic [PW-1:0]        b0;
        logic                 ge0;
        logic                 ge1;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] ang;

        if (k < W)
        begin : g_lane
            localparam int BI = W - 1 - k;
            logic [PW-1:0] ps_re;
            logic [PW-1:0] trial;
            logic          is_mag;

            assign is_mag = it_reg[k].tag.op == cau_pkg::OP_MAG;
            assign ps_re  = {it_reg[k].ln_re.p[PW-2:0], it_reg[k].ln_re.l[W-1]};
            assign ps_im  = {it_reg[k].ln_im.p[PW-2:0], it_reg[k].ln_im.l[W-1]};
            assign trial  = PW'({it_reg[k].ln_re.q, 2'b01}) << (2 * BI);
            assign a0     = is_mag ? it_reg[k].ln_re.p : ps_re;
            assign b0     = is_mag ? trial : it_reg[k].den;
            assign ge0    = a0 >= b0;
            assign ge1    = ps_im >= it_reg[k].den;
        end
        else
        begin : g_no_lane
            assign ps_im = '0;
            assign a0    = '0;
            assign b0    = '0;
            assign ge0   = 1'b0;
            assign ge1   = 1'b0;
        end

        if (k < CS)
        begin : g_rot
            assign dx  = $signed(it_reg[k].cord.y) >>> k;
            assign dy  = $signed(it_reg[k].cord.x) >>> k;
            assign ang = cau_pkg::angle_frac(cau_pkg::atan_q30(k), F);
        end
        else
        begin : g_no_rot
            assign dx  = '0;
            assign dy  = '0;
            assign ang = '0;
        end

        always_comb
        begin
            it_next = it_reg[k];
            if (k < W)
            begin
                it_next.ln_re.p = ge0 ? a0 - b0 : a0;
                it_next.ln_re.q = {it_reg[k].ln_re.q[W-2:0], ge0};
                it_next.ln_re.l = {it_reg[k].ln_re.l[W-2:0], 1'b0};
                it_next.ln_im.p = ge1 ? ps_im - it_reg[k].den : ps_im;
                it_next.ln_im.q = {it_reg[k].ln_im.q[W-2:0], ge1};
                it_next.ln_im.l = {it_reg[k].ln_im.l[W-2:0], 1'b0};
            end
            if (k < CS)
            begin
                // rotate towards the real axis
                if ($signed(it_reg[k].cord.y) > 0)
                begin
                    it_next.cord.x = it_reg[k].cord.x + dx;
                    it_next.cord.y = it_reg[k].cord.y - dy;
                    it_next.cord.z = it_reg[k].cord.z + ang;
                end
                else if ($signed(it_reg[k].cord.y) < 0)
                begin
                    it_next.cord.x = it_reg[k].cord.x - dx;
                    it_next.cord.y = it_reg[k].cord.y + dy;
                    it_next.cord.z = it_reg[k].cord.z - ang;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                it_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                it_valid_reg[k+1] <= it_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            it_reg[k+1] <= it_next;
        end
    end

    // final selection and saturation
    it_t          fin;
    sat_t         div_re;
    sat_t         div_im;
    sat_t         root;
    sat_t         angle;
    logic [W-1:0] res_re_next;
    logic [W-1:0] res_im_next;
    logic         ovf_next;

    assign fin    = it_reg[NIT];
    assign div_re = div_part(fin.ln_re.q, fin.neg_re, fin.big_re);
    assign div_im = div_part(fin.ln_im.q, fin.neg_im, fin.big_im);
    assign root   = sat_word(SW'({1'b0, fin.ln_re.q}));
    assign angle  = sat_word(SW'(fin.cord.z));

    always_comb
    begin
        unique case (fin.tag.op)
            cau_pkg::OP_DIV:
            begin
                if (fin.tag.dz)
                begin
                    res_re_next = '0;
                    res_im_next = '0;
                    ovf_next    = 1'b0;
                end
                else
                begin
                    res_re_next = div_re.val;
                    res_im_next = div_im.val;
                    ovf_next    = div_re.ovf | div_im.ovf;
                end
            end
            cau_pkg::OP_MAG:
            begin
                res_re_next = root.val;
                res_im_next = '0;
                ovf_next    = root.ovf;
            end
            cau_pkg::OP_ARG:
            begin
                res_re_next = angle.val;
                res_im_next = '0;
                ovf_next    = angle.ovf;
            end
            default:
            begin
                res_re_next = fin.tag.fin_re;
                res_im_next = fin.tag.fin_im;
                ovf_next    = fin.tag.ovf;
            end
        endcase
    end

    // output registers
    logic         done_reg;
    logic [W-1:0] res_real_reg;
    logic [W-1:0] res_imag_reg;
    logic         mag_less_reg;
    logic         mag_equal_reg;
    logic         mag_greater_reg;
    logic         div_by_zero_reg;
    logic         overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= it_valid_reg[NIT];
        end
    end

    always_ff @(posedge clk)
    begin
        res_real_reg    <= res_re_next;
        res_imag_reg    <= res_im_next;
        mag_less_reg    <= fin.tag.less;
        mag_equal_reg   <= fin.tag.equal;
        mag_greater_reg <= fin.tag.greater;
        div_by_zero_reg <= fin.tag.dz;
        overflow_reg    <= ovf_next;
    end

    assign done        = done_reg;
    assign res_real    = res_real_reg;
    assign res_imag    = res_imag_reg;
    assign mag_less    = mag_less_reg;
    assign mag_equal   = mag_equal_reg;
    assign mag_greater = mag_greater_reg;
    assign div_by_zero = div_by_zero_reg;
    assign overflow    = overflow_reg;

    // every accepted item comes out on done, and nothing else does
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item not delivered after the pipeline latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted item");

    // compare items carry exactly one ordering flag, all others none
    assert property (@(posedge clk) disable iff (!rst_n)
        (it_valid_reg[NIT] && fin.tag.op == cau_pkg::OP_CMP)
            |-> $onehot({fin.tag.less, fin.tag.equal, fin.tag.greater}))
        else $error("compare item without a single ordering flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        (it_valid_reg[NIT] && fin.tag.op != cau_pkg::OP_CMP)
            |-> !(fin.tag.less || fin.tag.equal || fin.tag.greater))
        else $error("ordering flag on a non-compare item");

    // a zero divisor gives a clean zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> (!overflow && res_real == '0 && res_imag == '0))
        else $error("division by zero result not cleared");

endmodule
